FILE: rtl/oad_pkg.sv
// Shared types, widths and codes for the obstacle-avoid drive block.
package oad_pkg;

  localparam int unsigned RangeW     = 12;
  localparam int unsigned TickCntW   = 16;
  localparam int unsigned SpeedCfgW  = 7;
  localparam int unsigned SpeedW     = 8;
  localparam int unsigned ModeW      = 4;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned InDataW    = 64;
  localparam int unsigned OutDataW   = 24;
  // Queue depth must stay a power of two: pointers wrap by overflow.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [SpeedCfgW-1:0] SpeedMax = SpeedCfgW'(100);
  localparam logic [TickCntW-1:0]  TickSat  = '1;

  typedef enum logic [CfgAddrW-1:0] {
    REG_GRAZE_LIMIT  = 3'd0,
    REG_SIDE_LIMIT   = 3'd1,
    REG_CENTRE_CLEAR = 3'd2,
    REG_START_WAIT   = 3'd3,
    REG_CRUISE_SPEED = 3'd4,
    REG_TURN_SPEED   = 3'd5,
    REG_GRAZE_FAST   = 3'd6,
    REG_GRAZE_SLOW   = 3'd7
  } cfg_reg_e;

  // Classifier verdict for one item.
  typedef enum logic [2:0] {
    CLS_FORWARD     = 3'd0,
    CLS_TURN_LEFT   = 3'd1,
    CLS_TURN_RIGHT  = 3'd2,
    CLS_SPIN_LEFT   = 3'd3,
    CLS_GRAZE_LEFT  = 3'd4,
    CLS_GRAZE_RIGHT = 3'd5
  } cls_e;

  typedef struct packed {
    logic [RangeW-1:0] graze;
    logic [RangeW-1:0] side;
    logic [RangeW-1:0] centre_clear;
  } limits_t;

  typedef struct packed {
    logic [TickCntW-1:0]  start_wait;
    logic [SpeedCfgW-1:0] cruise;
    logic [SpeedCfgW-1:0] turn;
    logic [SpeedCfgW-1:0] graze_fast;
    logic [SpeedCfgW-1:0] graze_slow;
  } drive_cfg_t;

  typedef struct packed {
    cls_e cls;
    logic tick;
  } q_entry_t;

endpackage

FILE: rtl/oad_front.sv
// Front end: takes input items and classifies the five range readings.
module oad_front import oad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [InDataW-1:0] s_data_i,
  input  limits_t            limits_i,
  input  logic               q_full_i,
  output logic               push_o,
  output q_entry_t           entry_o
);

  logic [RangeW-1:0] far_left, left, centre, right, far_right;
  logic              tick;
  logic              turn_l, turn_r;

  assign far_left  = s_data_i[RangeW-1:0];
  assign left      = s_data_i[2*RangeW-1:RangeW];
  assign centre    = s_data_i[3*RangeW-1:2*RangeW];
  assign right     = s_data_i[4*RangeW-1:3*RangeW];
  assign far_right = s_data_i[5*RangeW-1:4*RangeW];
  assign tick      = s_data_i[5*RangeW];

  assign turn_l = (right < limits_i.side) && (centre > limits_i.centre_clear)
                  && (left > limits_i.side);
  assign turn_r = (right > limits_i.side) && (centre > limits_i.centre_clear)
                  && (left < limits_i.side);

  always_comb begin
    entry_o.tick = tick;
    priority if (far_left < limits_i.graze) begin
      entry_o.cls = CLS_GRAZE_LEFT;
    end else if (far_right < limits_i.graze) begin
      entry_o.cls = CLS_GRAZE_RIGHT;
    end else if (turn_l) begin
      entry_o.cls = CLS_TURN_LEFT;
    end else if (turn_r) begin
      entry_o.cls = CLS_TURN_RIGHT;
    end else if (centre < limits_i.side) begin
      entry_o.cls = CLS_SPIN_LEFT;
    end else begin
      entry_o.cls = CLS_FORWARD;
    end
  end

  assign s_ready_o = !q_full_i;
  assign push_o    = s_valid_i && !q_full_i;

  // Classification must track the tick bit of the item it came from.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (entry_o.tick == s_data_i[5*RangeW]))
    else $error("front entry lost its tick bit");

endmodule

FILE: rtl/oad_queue.sv
// Short queue of classified items between front and back end.
module oad_queue import oad_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output q_entry_t pop_data_o
);

  q_entry_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   count_q, count_d;

  assign full_o     = (count_q == QueueCntW'(QueueDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntW'(QueueDepth))
    else $error("queue fill count overran");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("back end popped an empty queue");

endmodule

FILE: rtl/oad_back.sv
// Back end: drive state machine, wait counter, wheel speeds, output register.
module oad_back import oad_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  q_entry_t            q_data_i,
  output logic                pop_o,
  input  drive_cfg_t          cfg_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [OutDataW-1:0] m_data_o
);

  typedef enum logic [13:0] {
    ST_WAIT_SET     = 14'h0001,
    ST_WAITING      = 14'h0002,
    ST_FORWARD      = 14'h0004,
    ST_FORWARD_RUN  = 14'h0008,
    ST_TURN_L       = 14'h0010,
    ST_TURN_L_RUN   = 14'h0020,
    ST_TURN_R       = 14'h0040,
    ST_TURN_R_RUN   = 14'h0080,
    ST_SPIN_L       = 14'h0100,
    ST_SPIN_L_RUN   = 14'h0200,
    ST_GRAZE_L      = 14'h0400,
    ST_GRAZE_L_RUN  = 14'h0800,
    ST_GRAZE_R      = 14'h1000,
    ST_GRAZE_R_RUN  = 14'h2000
  } state_e;

  function automatic logic [ModeW-1:0] mode_code(state_e s);
    logic [ModeW-1:0] c;
    unique case (s)
      ST_WAIT_SET:    c = 4'd0;
      ST_WAITING:     c = 4'd1;
      ST_FORWARD:     c = 4'd2;
      ST_FORWARD_RUN: c = 4'd3;
      ST_TURN_L:      c = 4'd4;
      ST_TURN_L_RUN:  c = 4'd5;
      ST_TURN_R:      c = 4'd6;
      ST_TURN_R_RUN:  c = 4'd7;
      ST_SPIN_L:      c = 4'd8;
      ST_SPIN_L_RUN:  c = 4'd9;
      ST_GRAZE_L:     c = 4'd10;
      ST_GRAZE_L_RUN: c = 4'd11;
      ST_GRAZE_R:     c = 4'd12;
      ST_GRAZE_R_RUN: c = 4'd13;
      default:        c = 4'd0;
    endcase
    return c;
  endfunction

  function automatic state_e action_of(cls_e c);
    state_e s;
    unique case (c)
      CLS_TURN_LEFT:   s = ST_TURN_L;
      CLS_TURN_RIGHT:  s = ST_TURN_R;
      CLS_SPIN_LEFT:   s = ST_SPIN_L;
      CLS_GRAZE_LEFT:  s = ST_GRAZE_L;
      CLS_GRAZE_RIGHT: s = ST_GRAZE_R;
      default:         s = ST_FORWARD;
    endcase
    return s;
  endfunction

  function automatic logic [SpeedW-1:0] clamp_speed(logic [SpeedCfgW-1:0] v);
    return (v > SpeedMax) ? {1'b0, SpeedMax} : {1'b0, v};
  endfunction

  state_e              state_q, state_d;
  logic [TickCntW-1:0] wait_cnt_q, wait_cnt_d, cnt_inc;
  logic [SpeedW-1:0]   right_q, right_d, left_q, left_d;
  logic [SpeedW-1:0]   cruise_sp, turn_sp, fast_sp, slow_sp;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  state_e              run_action;

  assign cruise_sp = clamp_speed(cfg_i.cruise);
  assign turn_sp   = clamp_speed(cfg_i.turn);
  assign fast_sp   = clamp_speed(cfg_i.graze_fast);
  assign slow_sp   = clamp_speed(cfg_i.graze_slow);

  assign pop_o = q_valid_i && (!out_valid_q || m_ready_i);

  assign cnt_inc = (q_data_i.tick && (wait_cnt_q != TickSat)) ?
                   wait_cnt_q + 1'b1 : wait_cnt_q;
  assign run_action = action_of(q_data_i.cls);

  always_comb begin
    state_d    = state_q;
    wait_cnt_d = wait_cnt_q;
    right_d    = right_q;
    left_d     = left_q;
    if (pop_o) begin
      wait_cnt_d = cnt_inc;
      unique case (state_q)
        ST_WAIT_SET: begin
          wait_cnt_d = '0;
          right_d    = '0;
          left_d     = '0;
          state_d    = ST_WAITING;
        end
        ST_WAITING: begin
          if (cnt_inc > cfg_i.start_wait) begin
            state_d = ST_FORWARD;
          end
        end
        ST_FORWARD: begin
          right_d = cruise_sp;
          left_d  = cruise_sp;
          state_d = ST_FORWARD_RUN;
        end
        ST_TURN_L: begin
          right_d = turn_sp;
          left_d  = '0;
          state_d = ST_TURN_L_RUN;
        end
        ST_TURN_R: begin
          right_d = '0;
          left_d  = turn_sp;
          state_d = ST_TURN_R_RUN;
        end
        ST_SPIN_L: begin
          right_d = turn_sp;
          left_d  = -turn_sp;
          state_d = ST_SPIN_L_RUN;
        end
        ST_GRAZE_L: begin
          right_d = slow_sp;
          left_d  = fast_sp;
          state_d = ST_GRAZE_L_RUN;
        end
        ST_GRAZE_R: begin
          right_d = fast_sp;
          left_d  = slow_sp;
          state_d = ST_GRAZE_R_RUN;
        end
        ST_FORWARD_RUN: if (run_action != ST_FORWARD) state_d = run_action;
        ST_TURN_L_RUN:  if (run_action != ST_TURN_L)  state_d = run_action;
        ST_TURN_R_RUN:  if (run_action != ST_TURN_R)  state_d = run_action;
        ST_SPIN_L_RUN:  if (run_action != ST_SPIN_L)  state_d = run_action;
        ST_GRAZE_L_RUN: if (run_action != ST_GRAZE_L) state_d = run_action;
        ST_GRAZE_R_RUN: if (run_action != ST_GRAZE_R) state_d = run_action;
        default:        state_d = ST_WAIT_SET;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WAIT_SET;
      wait_cnt_q  <= '0;
      right_q     <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      wait_cnt_q <= wait_cnt_d;
      right_q    <= right_d;
      left_q     <= left_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= {4'd0, mode_code(state_d), left_d, right_d};
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && (state_q == ST_WAIT_SET)) |=> (wait_cnt_q == '0))
    else $error("wait counter not cleared on entry to waiting");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($signed(left_q) >= -8'sd100) && ($signed(left_q) <= 8'sd100)
    && ($signed(right_q) >= -8'sd100) && ($signed(right_q) <= 8'sd100))
    else $error("wheel speed out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_o |=> (state_q == $past(state_q)))
    else $error("drive state moved without an item");

endmodule

FILE: rtl/obstacle_avoid_drive_fsm.sv
// Top level of the obstacle-avoid drive block: config registers and wiring.
//
//  channel      | direction | contents
//  -------------+-----------+---------------------------------------------------
//  s_axis       | in        | one control step: five ranges and the ms tick
//  m_axis       | out       | wheel speeds and drive state after the step
//  cfg          | in        | register write: cfg_we_i, cfg_addr_i, cfg_wdata_i
//
// One item per clock sustained while m_axis_tready is high; from accept to result
// an item passes classifier -> queue -> state update into the output register.
// The classifier is combinational and the drive state update is registered; the
// two-entry queue lets the back end hold while the output is stalled.
// Reset (rst_ni, async, active low) loads the register defaults, empties the
// queue and puts the machine in the wait-set state with both wheels stopped.
module obstacle_avoid_drive_fsm import oad_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // far_left_range[11:0], left_range[23:12], centre_range[35:24],
  // right_range[47:36], far_right_range[59:48], ms_tick[60], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // right_wheel_speed[7:0], left_wheel_speed[15:8], drive_state[19:16], zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  limits_t    limits_q;
  drive_cfg_t drive_cfg_q;
  logic       q_full, q_push, q_valid, q_pop;
  q_entry_t   q_in, q_out;

  // Configuration registers; every index of the 3-bit address is in use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.graze          <= RangeW'(240);
      limits_q.side           <= RangeW'(640);
      limits_q.centre_clear   <= RangeW'(480);
      drive_cfg_q.start_wait  <= TickCntW'(1000);
      drive_cfg_q.cruise      <= SpeedCfgW'(25);
      drive_cfg_q.turn        <= SpeedCfgW'(15);
      drive_cfg_q.graze_fast  <= SpeedCfgW'(30);
      drive_cfg_q.graze_slow  <= SpeedCfgW'(10);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_GRAZE_LIMIT:  limits_q.graze         <= cfg_wdata_i[RangeW-1:0];
        REG_SIDE_LIMIT:   limits_q.side          <= cfg_wdata_i[RangeW-1:0];
        REG_CENTRE_CLEAR: limits_q.centre_clear  <= cfg_wdata_i[RangeW-1:0];
        REG_START_WAIT:   drive_cfg_q.start_wait <= cfg_wdata_i[TickCntW-1:0];
        REG_CRUISE_SPEED: drive_cfg_q.cruise     <= cfg_wdata_i[SpeedCfgW-1:0];
        REG_TURN_SPEED:   drive_cfg_q.turn       <= cfg_wdata_i[SpeedCfgW-1:0];
        REG_GRAZE_FAST:   drive_cfg_q.graze_fast <= cfg_wdata_i[SpeedCfgW-1:0];
        REG_GRAZE_SLOW:   drive_cfg_q.graze_slow <= cfg_wdata_i[SpeedCfgW-1:0];
        default: ;
      endcase
    end
  end

  // Front end: classification happens as the item is accepted.
  oad_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .limits_i  (limits_q),
    .q_full_i  (q_full),
    .push_o    (q_push),
    .entry_o   (q_in)
  );

  oad_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_out)
  );

  // Back end: drive state machine feeding the output register.
  oad_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_out),
    .pop_o     (q_pop),
    .cfg_i     (drive_cfg_q),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule
